// ----- rtl/lv3_pkg.sv -----
// Shared types and constants for the 3x3x3 local variance filter.
package lv3_pkg;

    localparam int TAPS       = 27;
    localparam int COORD_W    = 7;
    localparam int VAR_W      = 31;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_PAD_W  = OUT_DATA_W - 3 * COORD_W - VAR_W;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    localparam logic [CFG_W-1:0] SIZE_RESET = 8'd128;
    localparam logic [CFG_W-1:0] SIZE_MIN   = 8'd3;

    // exact variance divisor 27*26; it is at least 2^9, so the quotient is 9 bits
    // narrower than the numerator, and below 2^10, so 10 extra reciprocal bits
    // make the reciprocal multiply exact
    localparam int DIV_C     = 702;
    localparam int DIV_HEAD  = 9;
    localparam int DIV_GUARD = 10;

    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
        logic               last;
    } t_meta;

endpackage

// ----- rtl/local_variance_3x3x3.sv -----
// Top level of the streaming 3x3x3 local variance filter.
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+-----------------------------------------
//  s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready | tdata: voxel_value
//  m_axis    | out | o_m_axis_tvalid/i_m_axis_tready | tdata: cx,cy,cz,variance; tlast: last
//  cfg       | in  | i_cfg_we                     | i_cfg_idx, i_cfg_data
//
// One voxel beat per cycle while the output is not stalled. A result passes the
// window stage, five statistics stages, then two divider stages
// (half-width partial products of the reciprocal of 702, then their sum).
// Reset (synchronous, active low) clears positions, pointers and stage valids;
// delay memories are not cleared since every window tap is rewritten before use.
// A stalled output freezes only the stages that are full; bubbles keep draining,
// so input beats are still taken while a result waits.
// Border voxels take a beat but produce no result beat.
module local_variance_3x3x3 #(
    parameter int MAX_X       = 128,
    parameter int MAX_Y       = 128,
    parameter int MAX_Z       = 128,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lv3_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lv3_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [SAMPLE_BITS-1:0] voxel_value, rest zero
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [6:0] center_x, [13:7] center_y, [20:14] center_z, [51:21] variance, rest zero
    output logic [lv3_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // last_of_volume
    output logic                                o_m_axis_tlast
);
    localparam int NW = 2 * SAMPLE_BITS + 8;
    localparam int QW = NW - lv3_pkg::DIV_HEAD;

    logic win_valid, win_ready, st_valid, st_ready;
    logic [lv3_pkg::TAPS-1:0][SAMPLE_BITS-1:0] win;
    lv3_pkg::t_meta win_meta, st_meta, dv_meta;
    logic [NW-1:0] num;
    logic [QW-1:0] quo;
    logic [lv3_pkg::VAR_W-1:0] var_out;

    lv3_window #(
        .MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z), .SAMPLE_BITS(SAMPLE_BITS)
    ) u_win (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_sample   (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_valid    (win_valid),
        .i_ready    (win_ready),
        .o_win      (win),
        .o_meta     (win_meta)
    );

    lv3_stats #(.SAMPLE_BITS(SAMPLE_BITS)) u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (win_valid),
        .o_ready (win_ready),
        .i_win   (win),
        .i_meta  (win_meta),
        .o_valid (st_valid),
        .i_ready (st_ready),
        .o_num   (num),
        .o_meta  (st_meta)
    );

    lv3_div #(.NW(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (st_valid),
        .o_ready (st_ready),
        .i_num   (num),
        .i_meta  (st_meta),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_quo   (quo),
        .o_meta  (dv_meta)
    );

    // quotient wider than the field only for wide samples: clip there
    if (QW > lv3_pkg::VAR_W) begin : g_sat
        assign var_out = (quo[QW-1:lv3_pkg::VAR_W] != '0) ? '1 : quo[lv3_pkg::VAR_W-1:0];
    end else begin : g_ext
        assign var_out = lv3_pkg::VAR_W'(quo);
    end

    assign o_m_axis_tdata = {{lv3_pkg::OUT_PAD_W{1'b0}}, var_out,
                             dv_meta.cz, dv_meta.cy, dv_meta.cx};
    assign o_m_axis_tlast = dv_meta.last;

endmodule

// ----- rtl/lv3_window.sv -----
// Position tracking, line/plane delay memories and the 27-sample window register.
module lv3_window #(
    parameter int MAX_X       = 128,
    parameter int MAX_Y       = 128,
    parameter int MAX_Z       = 128,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [lv3_pkg::CFG_IDX_W-1:0]             i_cfg_idx,
    input  logic [lv3_pkg::CFG_W-1:0]                 i_cfg_data,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic [SAMPLE_BITS-1:0]                    i_sample,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [lv3_pkg::TAPS-1:0][SAMPLE_BITS-1:0] o_win,
    output lv3_pkg::t_meta                            o_meta
);
    localparam int B    = SAMPLE_BITS;
    localparam int SXW  = $clog2(MAX_X + 1);
    localparam int SYW  = $clog2(MAX_Y + 1);
    localparam int SZW  = $clog2(MAX_Z + 1);
    localparam int PXW  = $clog2(MAX_X);
    localparam int PYW  = $clog2(MAX_Y);
    localparam int PZW  = $clog2(MAX_Z);
    localparam int LD   = MAX_X - 1;
    localparam int PD   = MAX_X * (MAX_Y - 2) - 1;
    localparam int LPW  = $clog2(LD);
    localparam int PPW  = $clog2(PD);
    localparam int PRW  = SXW + SYW;

    logic [lv3_pkg::CFG_W-1:0] r_size_x, r_size_y, r_size_z;
    logic [SXW-1:0] sx;
    logic [SYW-1:0] sy;
    logic [SZW-1:0] sz;
    logic [PRW-1:0] plane_last;
    logic [PXW-1:0] r_pos_x;
    logic [PYW-1:0] r_pos_y;
    logic [PZW-1:0] r_pos_z;
    logic [LPW-1:0] r_lptr;
    logic [PPW-1:0] r_pptr;
    logic [6*B-1:0] line_mem [LD];
    logic [2*B-1:0] plane_mem [PD];
    logic [6*B-1:0] r_lrd;
    logic [2*B-1:0] r_prd;
    logic [B-1:0]   r_in;
    logic [8:0][B-1:0] t0, r_w1, r_w2;
    logic           acc, emit, end_x, end_y, end_z;
    logic           r_valid;
    lv3_pkg::t_meta r_meta, n_meta;
    logic [31:0]    ex, ey, ez;

    always_comb begin
        if (r_size_x < lv3_pkg::SIZE_MIN)      sx = SXW'(3);
        else if (32'(r_size_x) > MAX_X)         sx = SXW'(MAX_X);
        else                                    sx = SXW'(r_size_x);
        if (r_size_y < lv3_pkg::SIZE_MIN)      sy = SYW'(3);
        else if (32'(r_size_y) > MAX_Y)         sy = SYW'(MAX_Y);
        else                                    sy = SYW'(r_size_y);
        if (r_size_z < lv3_pkg::SIZE_MIN)      sz = SZW'(3);
        else if (32'(r_size_z) > MAX_Z)         sz = SZW'(MAX_Z);
        else                                    sz = SZW'(r_size_z);
    end

    // plane gap minus one entry, last pointer value is one below that
    assign plane_last = PRW'(PRW'(sx) * PRW'(sy - SYW'(2))) - PRW'(2);

    assign o_ready = !r_valid || i_ready;
    assign acc     = i_valid && o_ready;

    assign end_x = 32'(r_pos_x) == 32'(sx) - 32'd1;
    assign end_y = 32'(r_pos_y) == 32'(sy) - 32'd1;
    assign end_z = 32'(r_pos_z) == 32'(sz) - 32'd1;
    assign emit  = (r_pos_x >= PXW'(2)) && (r_pos_y >= PYW'(2)) && (r_pos_z >= PZW'(2));

    always_comb begin
        ex = 32'(r_pos_x) - 32'd1;
        ey = 32'(r_pos_y) - 32'd1;
        ez = 32'(r_pos_z) - 32'd1;
        n_meta.cx   = ex[lv3_pkg::COORD_W-1:0];
        n_meta.cy   = ey[lv3_pkg::COORD_W-1:0];
        n_meta.cz   = ez[lv3_pkg::COORD_W-1:0];
        n_meta.last = end_x && end_y && end_z;
    end

    // tap 0 of each window row: row k = plane*3 + line
    always_comb begin
        t0[0] = r_in;
        t0[1] = r_lrd[0*B +: B];
        t0[2] = r_lrd[1*B +: B];
        t0[3] = r_prd[0*B +: B];
        t0[4] = r_lrd[2*B +: B];
        t0[5] = r_lrd[3*B +: B];
        t0[6] = r_prd[1*B +: B];
        t0[7] = r_lrd[4*B +: B];
        t0[8] = r_lrd[5*B +: B];
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            o_win[k*3]     = t0[k];
            o_win[k*3 + 1] = r_w1[k];
            o_win[k*3 + 2] = r_w2[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_lrd <= line_mem[r_lptr];
            line_mem[r_lptr] <= {t0[7], t0[6], t0[4], t0[3], t0[1], t0[0]};
            r_prd <= plane_mem[r_pptr];
            plane_mem[r_pptr] <= {t0[5], t0[2]};
            r_in  <= i_sample;
            r_w1  <= t0;
            r_w2  <= r_w1;
        end
        if (acc) begin
            r_meta <= n_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= lv3_pkg::SIZE_RESET;
            r_size_y <= lv3_pkg::SIZE_RESET;
            r_size_z <= lv3_pkg::SIZE_RESET;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_pos_z  <= '0;
            r_lptr   <= '0;
            r_pptr   <= '0;
            r_valid  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lv3_pkg::REG_SIZE_X: r_size_x <= i_cfg_data;
                lv3_pkg::REG_SIZE_Y: r_size_y <= i_cfg_data;
                lv3_pkg::REG_SIZE_Z: r_size_z <= i_cfg_data;
                default: ;
            endcase
            if (i_cfg_idx == lv3_pkg::REG_SIZE_X || i_cfg_idx == lv3_pkg::REG_SIZE_Y
                || i_cfg_idx == lv3_pkg::REG_SIZE_Z) begin
                r_pos_x <= '0;
                r_pos_y <= '0;
                r_pos_z <= '0;
                r_lptr  <= '0;
                r_pptr  <= '0;
            end
            if (i_ready) r_valid <= 1'b0;
        end else if (acc) begin
            r_valid <= emit;
            r_lptr  <= (SXW'(r_lptr) == sx - SXW'(2)) ? '0 : r_lptr + LPW'(1);
            r_pptr  <= (PRW'(r_pptr) == plane_last) ? '0 : r_pptr + PPW'(1);
            if (end_x) begin
                r_pos_x <= '0;
                if (end_y) begin
                    r_pos_y <= '0;
                    r_pos_z <= end_z ? '0 : r_pos_z + PZW'(1);
                end else begin
                    r_pos_y <= r_pos_y + PYW'(1);
                end
            end else begin
                r_pos_x <= r_pos_x + PXW'(1);
            end
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_meta  = r_meta;

endmodule

// ----- rtl/lv3_stats.sv -----
// Sum, sum of squares and numerator 27*Q - S^2 over five pipeline stages.
module lv3_stats #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic [lv3_pkg::TAPS-1:0][SAMPLE_BITS-1:0] i_win,
    input  lv3_pkg::t_meta                            i_meta,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [2*SAMPLE_BITS+7:0]                  o_num,
    output lv3_pkg::t_meta                            o_meta
);
    localparam int B    = SAMPLE_BITS;
    localparam int SQW  = 2 * B - 1;
    localparam int S9W  = B + 4;
    localparam int SW   = B + 5;
    localparam int MW   = B + 4;
    localparam int Q9W  = 2 * B + 2;
    localparam int QW   = 2 * B + 3;
    localparam int NW   = 2 * B + 8;
    localparam int NST  = 5;

    logic [NST-1:0] r_v, en;
    lv3_pkg::t_meta r_meta [NST];

    logic [lv3_pkg::TAPS-1:0][SQW-1:0] r_sq, n_sq;
    logic [2:0][S9W-1:0] r_s9, n_s9;
    logic [2:0][Q9W-1:0] r_q9, n_q9;
    logic [SW-1:0]       r_s, n_s;
    logic [QW-1:0]       r_q, n_q;
    logic [MW-1:0]       r_mag, n_mag;
    logic [NW-1:0]       r_q27, r_s2, r_num;

    always_comb begin
        en[NST-1] = !r_v[NST-1] || i_ready;
        for (int i = NST - 2; i >= 0; i--) en[i] = !r_v[i] || en[i+1];
    end
    assign o_ready = en[0];

    // stage 1: squares per tap, partial sums per plane
    always_comb begin
        logic signed [2*B-1:0] p;
        logic signed [S9W-1:0] acc9;
        for (int t = 0; t < lv3_pkg::TAPS; t++) begin
            p = $signed(i_win[t]) * $signed(i_win[t]);
            n_sq[t] = p[SQW-1:0];
        end
        for (int g = 0; g < 3; g++) begin
            acc9 = '0;
            for (int t = 0; t < 9; t++) acc9 = acc9 + S9W'($signed(i_win[g*9 + t]));
            n_s9[g] = acc9;
        end
    end

    // stage 2: square partials, total sum
    always_comb begin
        logic [Q9W-1:0] acq;
        for (int g = 0; g < 3; g++) begin
            acq = '0;
            for (int t = 0; t < 9; t++) acq = acq + Q9W'(r_sq[g*9 + t]);
            n_q9[g] = acq;
        end
        n_s = SW'($signed(r_s9[0])) + SW'($signed(r_s9[1])) + SW'($signed(r_s9[2]));
    end

    // stage 3: total of squares, magnitude of the sum
    always_comb begin
        logic [SW-1:0] neg;
        n_q = QW'(r_q9[0]) + QW'(r_q9[1]) + QW'(r_q9[2]);
        neg = -r_s;
        n_mag = r_s[SW-1] ? neg[MW-1:0] : r_s[MW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_sq <= n_sq; r_s9 <= n_s9; r_meta[0] <= i_meta;
        end
        if (en[1]) begin
            r_q9 <= n_q9; r_s <= n_s; r_meta[1] <= r_meta[0];
        end
        if (en[2]) begin
            r_q <= n_q; r_mag <= n_mag; r_meta[2] <= r_meta[1];
        end
        if (en[3]) begin
            r_q27 <= NW'(r_q) * NW'(27);
            r_s2  <= NW'(r_mag) * NW'(r_mag);
            r_meta[3] <= r_meta[2];
        end
        if (en[4]) begin
            r_num <= r_q27 - r_s2; r_meta[4] <= r_meta[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int i = 1; i < NST; i++) if (en[i]) r_v[i] <= r_v[i-1];
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_num   = r_num;
    assign o_meta  = r_meta[NST-1];

endmodule

// ----- rtl/lv3_div.sv -----
// Divide by 702 through a reciprocal multiply, two pipeline stages.
module lv3_div #(
    parameter int NW = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [NW-1:0]        i_num,
    input  lv3_pkg::t_meta       i_meta,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [NW-lv3_pkg::DIV_HEAD-1:0] o_quo,
    output lv3_pkg::t_meta       o_meta
);
    localparam int QW  = NW - lv3_pkg::DIV_HEAD;
    localparam int K   = NW + lv3_pkg::DIV_GUARD;
    localparam int MBW = NW + 1;
    localparam int LW  = NW / 2;
    localparam int NHW = NW - LW;
    localparam int MHW = MBW - LW;
    localparam int PW  = 2 * NW + 1;
    localparam int HHW = NHW + MHW;
    localparam int HLW = NHW + LW;
    localparam int LHW = LW + MHW;
    localparam int LLW = 2 * LW;

    // reciprocal ceil(2^K / 702); floor(n*MUL / 2^K) equals floor(n / 702)
    localparam logic [K:0]     POW_K = (K+1)'(1) << K;
    localparam logic [K:0]     MUL_W = (POW_K + (K+1)'(lv3_pkg::DIV_C - 1))
                                       / (K+1)'(lv3_pkg::DIV_C);
    localparam logic [MBW-1:0] MUL   = MUL_W[MBW-1:0];
    localparam logic [MHW-1:0] MUL_H = MUL[MBW-1:LW];
    localparam logic [LW-1:0]  MUL_L = MUL[LW-1:0];

    logic [1:0]     r_v, en;
    lv3_pkg::t_meta r_meta [2];
    logic [HHW-1:0] r_hh;
    logic [HLW-1:0] r_hl;
    logic [LHW-1:0] r_lh;
    logic [LLW-1:0] r_ll;
    logic [PW-1:0]  prod;
    logic [QW-1:0]  r_quo;

    assign en[1]   = !r_v[1] || i_ready;
    assign en[0]   = !r_v[0] || en[1];
    assign o_ready = en[0];

    // recombine the four half-width partial products
    assign prod = (PW'(r_hh) << (2 * LW)) + (PW'(r_hl) << LW) + (PW'(r_lh) << LW)
                  + PW'(r_ll);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_hh <= HHW'(i_num[NW-1:LW]) * HHW'(MUL_H);
            r_hl <= HLW'(i_num[NW-1:LW]) * HLW'(MUL_L);
            r_lh <= LHW'(i_num[LW-1:0]) * LHW'(MUL_H);
            r_ll <= LLW'(i_num[LW-1:0]) * LLW'(MUL_L);
            r_meta[0] <= i_meta;
        end
        if (en[1]) begin
            r_quo     <= prod[K +: QW];
            r_meta[1] <= r_meta[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
        end
    end

    assign o_valid = r_v[1];
    assign o_quo   = r_quo;
    assign o_meta  = r_meta[1];

endmodule

// ----- rtl/lv3_chk.sv -----
// Port-level checks for the local variance filter, bound to the top level.
module lv3_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [lv3_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input logic                            o_m_axis_tlast
);
    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result beat changed while stalled");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // with no result pending nothing can block the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    // interior centres never sit on coordinate zero
    a_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[6:0] != 7'd0 && o_m_axis_tdata[13:7] != 7'd0
            && o_m_axis_tdata[20:14] != 7'd0)
        else $error("border coordinate on result");

endmodule

bind local_variance_3x3x3 lv3_chk u_lv3_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the 3x3x3 local variance filter.
module tb_top;
    import lv3_pkg::*;

    localparam int LINE_MAX  = 128;
    localparam int WIN_LEN   = 2 * LINE_MAX * LINE_MAX + 2 * LINE_MAX + 3;
    localparam int DRAIN_CYC = 30;     // past the end of the pipeline
    localparam int STALL_CAP = 2000;   // cycles with no beat before giving up
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [COORD_W-1:0] cx, cy, cz;
        logic [VAR_W-1:0]   var_q;
        logic               last;
    } t_var_result;

    // Tracks the filter window and volume position, predicts each result.
    class variance_board;
        int                 win [WIN_LEN];
        int                 wr_pos;
        int                 px, py, pz;
        logic [CFG_W-1:0]   size_raw [3];
        t_var_result        pending [$];
        int                 errors;

        function new();
            wr_pos = 0; px = 0; py = 0; pz = 0; errors = 0;
            foreach (win[i]) win[i] = 0;
            foreach (size_raw[i]) size_raw[i] = SIZE_RESET;
        endfunction

        function int eff_size(int r);
            int v;
            v = size_raw[r];
            if (v < 3) return 3;
            if (v > LINE_MAX) return LINE_MAX;
            return v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_UNUSED) return;
            size_raw[idx] = val;
            px = 0; py = 0; pz = 0;
        endfunction

        function void take_voxel(logic signed [15:0] voxel);
            int sx, sy, sz, back, k;
            longint s, q;
            longint unsigned num, quo;
            t_var_result r;
            sx = eff_size(0); sy = eff_size(1); sz = eff_size(2);
            win[wr_pos] = voxel;
            if (px >= 2 && py >= 2 && pz >= 2) begin
                s = 0; q = 0;
                for (int c = 0; c < 3; c++)
                    for (int b = 0; b < 3; b++)
                        for (int a = 0; a < 3; a++) begin
                            back = a + b * sx + c * sx * sy;
                            k = wr_pos + WIN_LEN - back;
                            if (k >= WIN_LEN) k -= WIN_LEN;
                            s += win[k];
                            q += longint'(win[k]) * win[k];
                        end
                num = 27 * q - s * s;
                quo = num / DIV_C;
                if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
                r.cx = COORD_W'(px - 1);
                r.cy = COORD_W'(py - 1);
                r.cz = COORD_W'(pz - 1);
                r.var_q = quo[VAR_W-1:0];
                r.last = (px == sx - 1 && py == sy - 1 && pz == sz - 1);
                pending.push_back(r);
            end
            wr_pos = (wr_pos + 1 == WIN_LEN) ? 0 : wr_pos + 1;
            px++;
            if (px >= sx) begin
                px = 0; py++;
                if (py >= sy) begin
                    py = 0; pz++;
                    if (pz >= sz) pz = 0;
                end
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
            t_var_result e;
            bit bad;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: data=%h last=%0d", data, last);
                return;
            end
            e = pending.pop_front();
            bad = (data[6:0] !== e.cx) || (data[13:7] !== e.cy) ||
                  (data[20:14] !== e.cz) || (data[51:21] !== e.var_q) ||
                  (last !== e.last);
            if (bad) begin
                errors++;
                if (errors <= 10)
                    $display(
                        "mismatch: exp (%0d,%0d,%0d) v=%0d l=%0d got (%0d,%0d,%0d) v=%0d l=%0d",
                        e.cx, e.cy, e.cz, e.var_q, e.last,
                        data[6:0], data[13:7], data[20:14], data[51:21], last);
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx = '0;
    logic [CFG_W-1:0]           i_cfg_data = '0;
    logic                       i_s_axis_tvalid = 1'b0;
    logic                       o_s_axis_tready;
    logic [15:0]                i_s_axis_tdata = '0;    // [15:0] voxel_value
    logic                       o_m_axis_tvalid;
    logic                       i_m_axis_tready = 1'b0;
    // [6:0] cx, [13:7] cy, [20:14] cz, [51:21] variance, rest zero
    logic [OUT_DATA_W-1:0]      o_m_axis_tdata;
    logic                       o_m_axis_tlast;          // last_of_volume

    variance_board board = new();
    bit  quiet = 1'b0;      // no idling on either side in the closing stretch
    int  stall_left = 0;
    int  idle_cycles = 0;

    local_variance_3x3x3 u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata), .o_m_axis_tlast(o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check each beat, stall in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_result(o_m_axis_tdata, o_m_axis_tlast);
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = int'($urandom_range(1, 9)) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // watchdog: ends a run in which no beat moves for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_CAP) begin
            $display("[local_variance_3x3x3] ERROR");
            $finish;
        end
    end

    // one voxel beat, with an optional random gap first
    task automatic send_voxel(logic [15:0] v);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= v;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.take_voxel(v);
    endtask

    // block must be drained before its sizes change
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        board.write_reg(idx, val);
    endtask

    task automatic set_sizes(logic [CFG_W-1:0] sx, logic [CFG_W-1:0] sy,
                             logic [CFG_W-1:0] sz);
        settle();
        write_reg(REG_SIZE_X, sx);
        write_reg(REG_SIZE_Y, sy);
        write_reg(REG_SIZE_Z, sz);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_voxel();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            2: return 16'($urandom_range(0, 40) - 20);
            default: return 16'($urandom_range(0, 2000) + 1000);
        endcase
    endfunction

    initial begin
        int nvox;
        logic [CFG_W-1:0] rx, ry, rz;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest volume, alternating full-scale samples: largest variance
        set_sizes(8'd3, 8'd3, 8'd3);
        for (int i = 0; i < 27; i++)
            send_voxel((i % 2) ? 16'h7FFF : 16'h8000);

        // below-minimum sizes act as 3; unused index must not restart the volume
        set_sizes(8'd0, 8'd1, 8'd2);
        for (int i = 0; i < 13; i++) send_voxel(pick_voxel());
        settle();
        write_reg(REG_UNUSED, 8'd5);
        i_cfg_we <= 1'b0;
        for (int i = 0; i < 14 + 27; i++) send_voxel(pick_voxel());

        // oversize depth clamps to 128 planes; volume cut short
        set_sizes(8'd3, 8'd3, 8'd200);
        for (int i = 0; i < 9 * 10; i++) send_voxel(pick_voxel());

        // random small volumes, often cut short by the next size change
        for (int ph = 0; ph < 6; ph++) begin
            rx = CFG_W'($urandom_range(3, 7));
            ry = CFG_W'($urandom_range(3, 6));
            rz = CFG_W'($urandom_range(3, 5));
            if (ph == 5) quiet = 1'b1;
            set_sizes(rx, ry, rz);
            nvox = rx * ry * rz * $urandom_range(1, 2);
            if (ph % 3 == 2) nvox = $urandom_range(10, nvox);
            for (int i = 0; i < nvox; i++) send_voxel(pick_voxel());
        end

        i_s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (board.errors == 0)
            $display("[local_variance_3x3x3] OK");
        else
            $display("[local_variance_3x3x3] ERROR");
        $finish;
    end
endmodule
